[rtl/lbcp_pkg.sv]
package lbcp_pkg;

  localparam int COEF_W  = 32;
  localparam int NUM_W   = 64;
  localparam int COORD_W = 31;
  localparam int NLANE   = 4;
  localparam int CFG_W   = 31;
  localparam int CFGIX_W = 3;
  localparam int ORG_W   = 12;

  typedef enum logic [CFGIX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_PLOT_HEIGHT = 3'd2,
    REG_SCALE_X     = 3'd3,
    REG_SCALE_Y     = 3'd4,
    REG_EXTENT_X    = 3'd5,
    REG_EXTENT_Y    = 3'd6
  } cfg_reg_t;

  // x above y: a plain unsigned compare orders by x, then by y
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic   ok;
    point_t pt;
  } cand_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;   // numerator bits still to bring down, MSB first
    logic [COEF_W-1:0]  den;
    logic [COEF_W-1:0]  rem;
    logic [COORD_W-1:0] quo;
    logic               keep; // divisor nonzero and quotient fits
    logic               neg;  // quotient below zero
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t d);
    logic [COEF_W:0] t;
    logic [COEF_W:0] diff;
    div_lane_t       r;
    t      = {d.rem, d.lo[COORD_W-1]};
    diff   = t - {1'b0, d.den};
    r      = d;
    r.lo   = {d.lo[COORD_W-2:0], 1'b0};
    if (t >= {1'b0, d.den}) begin
      r.rem = diff[COEF_W-1:0];
      r.quo = {d.quo[COORD_W-2:0], 1'b1};
    end else begin
      r.rem = t[COEF_W-1:0];
      r.quo = {d.quo[COORD_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // true when p belongs after q; dropped candidates sort last
  function automatic logic cand_after(cand_t p, cand_t q);
    return (!p.ok && q.ok) || (p.ok && q.ok && (p.pt > q.pt));
  endfunction

endpackage

[rtl/lbcp_prep.sv]
module lbcp_prep import lbcp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] rhs,
  input  logic [COORD_W-1:0]       extent_x,
  input  logic [COORD_W-1:0]       extent_y,
  output logic                     lane_valid,
  output div_lane_t [NLANE-1:0]    lane
);

  logic signed [COEF_W-1:0] a1_r, b1_r, c1_r;
  logic signed [NUM_W-1:0]  pa1_r, pb1_r;
  logic signed [NUM_W-1:0]  pa_nxt, pb_nxt;
  logic                     v1_r;

  logic signed [NUM_W-1:0]  n2_r [NLANE];
  logic signed [COEF_W-1:0] d2_r [NLANE];
  logic signed [NUM_W-1:0]  n2_nxt [NLANE];
  logic signed [COEF_W-1:0] d2_nxt [NLANE];
  logic signed [NUM_W-1:0]  csh;
  logic                     v2_r;

  logic [NUM_W-1:0]  nabs3_r [NLANE];
  logic [COEF_W-1:0] dabs3_r [NLANE];
  logic              neg3_r  [NLANE];
  logic              dnz3_r  [NLANE];
  logic [NUM_W-1:0]  nabs3_nxt [NLANE];
  logic [COEF_W-1:0] dabs3_nxt [NLANE];
  logic              neg3_nxt  [NLANE];
  logic              dnz3_nxt  [NLANE];
  logic              v3_r;

  div_lane_t [NLANE-1:0] lane_r, lane_nxt;
  logic                  v4_r;

  // products of the two far edges
  assign pa_nxt = coef_a * $signed({1'b0, extent_x});
  assign pb_nxt = coef_b * $signed({1'b0, extent_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r  <= coef_a;
    b1_r  <= coef_b;
    c1_r  <= rhs;
    pa1_r <= pa_nxt;
    pb1_r <= pb_nxt;
  end

  // lanes: y=0, x=0, y=extent_y, x=extent_x
  always_comb begin
    csh       = NUM_W'(c1_r) <<< FRAC_BITS;
    n2_nxt[0] = csh;
    n2_nxt[1] = csh;
    n2_nxt[2] = csh - pb1_r;
    n2_nxt[3] = csh - pa1_r;
    d2_nxt[0] = a1_r;
    d2_nxt[1] = b1_r;
    d2_nxt[2] = a1_r;
    d2_nxt[3] = b1_r;
  end

  always_ff @(posedge clk) begin
    n2_r <= n2_nxt;
    d2_r <= d2_nxt;
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      nabs3_nxt[l] = n2_r[l][NUM_W-1] ? NUM_W'(-n2_r[l]) : NUM_W'(n2_r[l]);
      dabs3_nxt[l] = d2_r[l][COEF_W-1] ? COEF_W'(-d2_r[l]) : COEF_W'(d2_r[l]);
      neg3_nxt[l]  = (n2_r[l][NUM_W-1] ^ d2_r[l][COEF_W-1]) && (n2_r[l] != '0);
      dnz3_nxt[l]  = (d2_r[l] != '0);
    end
  end

  always_ff @(posedge clk) begin
    nabs3_r <= nabs3_nxt;
    dabs3_r <= dabs3_nxt;
    neg3_r  <= neg3_nxt;
    dnz3_r  <= dnz3_nxt;
  end

  // quotient fits in COORD_W bits only if numerator < divisor * 2^COORD_W
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      lane_nxt[l].lo   = nabs3_r[l][COORD_W-1:0];
      lane_nxt[l].rem  = nabs3_r[l][COORD_W +: COEF_W];
      lane_nxt[l].den  = dabs3_r[l];
      lane_nxt[l].quo  = '0;
      lane_nxt[l].neg  = neg3_r[l];
      lane_nxt[l].keep = dnz3_r[l] &&
                         (nabs3_r[l] < {1'b0, dabs3_r[l], {COORD_W{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_valid = v4_r;
  assign lane       = lane_r;

endmodule

[rtl/lbcp_div.sv]
module lbcp_div import lbcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  div_lane_t [NLANE-1:0] in_lane,
  output logic                  out_valid,
  output div_lane_t [NLANE-1:0] out_lane
);

  div_lane_t [NLANE-1:0] st_r [COORD_W];
  logic [COORD_W-1:0]    v_r;

  for (genvar s = 0; s < COORD_W; s++) begin : g_stage
    div_lane_t [NLANE-1:0] src;
    div_lane_t [NLANE-1:0] st_nxt;
    logic                  src_v;

    if (s == 0) begin : g_first
      assign src   = in_lane;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = st_r[s-1];
      assign src_v = v_r[s-1];
    end

    // one quotient bit per stage on each lane
    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        st_nxt[l] = div_step(src[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      st_r[s] <= st_nxt;
    end
  end

  assign out_valid = v_r[COORD_W-1];
  assign out_lane  = st_r[COORD_W-1];

endmodule

[rtl/lbcp_select.sv]
module lbcp_select import lbcp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  div_lane_t [NLANE-1:0] lane,
  input  logic [COORD_W-1:0]    extent_x,
  input  logic [COORD_W-1:0]    extent_y,
  output logic                  out_valid,
  output logic                  visible,
  output point_t                p0,
  output point_t                p1
);

  cand_t c_r [NLANE];
  cand_t c_nxt [NLANE];
  cand_t l1_r [NLANE];
  cand_t l1_nxt [NLANE];
  cand_t l2_r [NLANE];
  cand_t l2_nxt [NLANE];
  cand_t l3_r [NLANE];
  cand_t l3_nxt [NLANE];
  logic  ok [NLANE];
  logic [4:0] v_r;

  logic   vis_r, vis_nxt;
  point_t p0_r, p0_nxt, p1_r, p1_nxt;

  // a negative quotient survives only when it truncated to zero
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      ok[l] = lane[l].keep && (!lane[l].neg || (lane[l].quo == '0)) &&
              (lane[l].quo <= (((l % 2) == 0) ? extent_x : extent_y));
    end
    c_nxt[0] = '{ok: ok[0], pt: '{x: lane[0].quo, y: '0}};
    c_nxt[1] = '{ok: ok[1], pt: '{x: '0, y: lane[1].quo}};
    c_nxt[2] = '{ok: ok[2], pt: '{x: lane[2].quo, y: extent_y}};
    c_nxt[3] = '{ok: ok[3], pt: '{x: extent_x, y: lane[3].quo}};
  end

  // four-input sorting network, one comparator layer per stage
  always_comb begin
    l1_nxt = c_r;
    if (cand_after(c_r[0], c_r[1])) begin
      l1_nxt[0] = c_r[1];
      l1_nxt[1] = c_r[0];
    end
    if (cand_after(c_r[2], c_r[3])) begin
      l1_nxt[2] = c_r[3];
      l1_nxt[3] = c_r[2];
    end
  end

  always_comb begin
    l2_nxt = l1_r;
    if (cand_after(l1_r[0], l1_r[2])) begin
      l2_nxt[0] = l1_r[2];
      l2_nxt[2] = l1_r[0];
    end
    if (cand_after(l1_r[1], l1_r[3])) begin
      l2_nxt[1] = l1_r[3];
      l2_nxt[3] = l1_r[1];
    end
  end

  always_comb begin
    l3_nxt = l2_r;
    if (cand_after(l2_r[1], l2_r[2])) begin
      l3_nxt[1] = l2_r[2];
      l3_nxt[2] = l2_r[1];
    end
  end

  // duplicates of the first point sit right behind it
  always_comb begin
    p0_nxt  = l3_r[0].pt;
    p1_nxt  = l3_r[1].pt;
    vis_nxt = 1'b0;
    if (l3_r[1].ok && (l3_r[1].pt != l3_r[0].pt)) begin
      vis_nxt = l3_r[0].ok;
    end else if (l3_r[2].ok && (l3_r[2].pt != l3_r[0].pt)) begin
      p1_nxt  = l3_r[2].pt;
      vis_nxt = l3_r[0].ok;
    end else if (l3_r[3].ok && (l3_r[3].pt != l3_r[0].pt)) begin
      p1_nxt  = l3_r[3].pt;
      vis_nxt = l3_r[0].ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    l1_r  <= l1_nxt;
    l2_r  <= l2_nxt;
    l3_r  <= l3_nxt;
    vis_r <= vis_nxt;
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
  end

  assign out_valid = v_r[4];
  assign visible   = vis_r;
  assign p0        = p0_r;
  assign p1        = p1_r;

endmodule

[rtl/lbcp_pixel.sv]
module lbcp_pixel import lbcp_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_visible,
  input  point_t                p0,
  input  point_t                p1,
  input  logic [COORD_W-1:0]    scale_x,
  input  logic [COORD_W-1:0]    scale_y,
  input  logic [ORG_W-1:0]      origin_x,
  input  logic [ORG_W-1:0]      origin_y,
  input  logic [ORG_W-1:0]      plot_height,
  output logic                  out_valid,
  output logic                  out_visible,
  output logic [PIXEL_BITS-1:0] start_x,
  output logic [PIXEL_BITS-1:0] start_y,
  output logic [PIXEL_BITS-1:0] end_x,
  output logic [PIXEL_BITS-1:0] end_y
);

  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'((1 << PIXEL_BITS) - 1);

  function automatic logic [PIXEL_BITS-1:0] clamp_pix(logic signed [SUM_W-1:0] v);
    logic [PIXEL_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > PIX_MAX) begin
      r = PIX_MAX[PIXEL_BITS-1:0];
    end else begin
      r = v[PIXEL_BITS-1:0];
    end
    return r;
  endfunction

  logic [PROD_W-1:0] mx0_r, my0_r, mx1_r, my1_r;
  logic              vism_r;
  logic [1:0]        v_r;

  logic [PROD_W-1:0]       shx0, shy0, shx1, shy1;
  logic signed [SUM_W-1:0] sx0, sy0, sx1, sy1;

  logic                  vis_r;
  logic [PIXEL_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [PIXEL_BITS-1:0] sx_nxt, sy_nxt, ex_nxt, ey_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    mx0_r  <= p0.x * scale_x;
    my0_r  <= p0.y * scale_y;
    mx1_r  <= p1.x * scale_x;
    my1_r  <= p1.y * scale_y;
    vism_r <= in_visible;
  end

  always_comb begin
    shx0 = mx0_r >> (2 * FRAC_BITS);
    shy0 = my0_r >> (2 * FRAC_BITS);
    shx1 = mx1_r >> (2 * FRAC_BITS);
    shy1 = my1_r >> (2 * FRAC_BITS);
    sx0  = $signed(SUM_W'(origin_x)) + $signed(SUM_W'(shx0));
    sx1  = $signed(SUM_W'(origin_x)) + $signed(SUM_W'(shx1));
    sy0  = $signed(SUM_W'(origin_y)) + $signed(SUM_W'(plot_height)) - $signed(SUM_W'(shy0));
    sy1  = $signed(SUM_W'(origin_y)) + $signed(SUM_W'(plot_height)) - $signed(SUM_W'(shy1));
    sx_nxt = '0;
    sy_nxt = '0;
    ex_nxt = '0;
    ey_nxt = '0;
    if (vism_r) begin
      sx_nxt = clamp_pix(sx0);
      sy_nxt = clamp_pix(sy0);
      ex_nxt = clamp_pix(sx1);
      ey_nxt = clamp_pix(sy1);
    end
  end

  always_ff @(posedge clk) begin
    vis_r <= vism_r;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    ex_r  <= ex_nxt;
    ey_r  <= ey_nxt;
  end

  assign out_valid   = v_r[1];
  assign out_visible = vis_r;
  assign start_x     = sx_r;
  assign start_y     = sy_r;
  assign end_x       = ex_r;
  assign end_y       = ey_r;

endmodule

[rtl/line_box_clip_to_pixels_unit.sv]
// Clips the line a*x + b*y = c (signed fixed point) to the box spanned by
// the origin and (extent_x, extent_y), and maps the two ends to pixels.
// Input: drive in_coef_a, in_coef_b, in_rhs with start high; the request is
// taken at any edge where busy is low. busy stays low: a new line may enter
// every cycle, so throughput is one line per clock.
// Output: out_strobe is high for one cycle with out_visible and the four
// pixel coordinates; the receiver cannot stall, so nothing is held back.
// From the taking edge a line passes through products, numerators and
// magnitudes, then the four one-bit-per-stage dividers, then candidate
// check, sort and merge, and last the scale multiply and the offset with
// clamping, before the strobe.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// write only while no line is in flight.
// Reset (synchronous, rst_n low) clears the pipeline valid bits and loads
// the register defaults; lines in flight are dropped.
module line_box_clip_to_pixels_unit import lbcp_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int PIXEL_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COEF_W-1:0] in_coef_a,
  input  logic signed [COEF_W-1:0] in_coef_b,
  input  logic signed [COEF_W-1:0] in_rhs,
  input  logic                     cfg_we,
  input  logic [CFGIX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     out_strobe,
  output logic                     out_visible,
  output logic [PIXEL_BITS-1:0]    out_start_x,
  output logic [PIXEL_BITS-1:0]    out_start_y,
  output logic [PIXEL_BITS-1:0]    out_end_x,
  output logic [PIXEL_BITS-1:0]    out_end_y
);

  logic [ORG_W-1:0]   origin_x_r, origin_y_r, plot_height_r;
  logic [COORD_W-1:0] scale_x_r, scale_y_r, extent_x_r, extent_y_r;

  logic                  take;
  logic                  prep_v, div_v, sel_v, sel_vis;
  div_lane_t [NLANE-1:0] prep_lane, div_lane;
  point_t                sel_p0, sel_p1;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= ORG_W'(40);
      origin_y_r    <= '0;
      plot_height_r <= ORG_W'(780);
      scale_x_r     <= COORD_W'(65536);
      scale_y_r     <= COORD_W'(65536);
      extent_x_r    <= COORD_W'(65536);
      extent_y_r    <= COORD_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin_x_r    <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:    origin_y_r    <= cfg_data[ORG_W-1:0];
        REG_PLOT_HEIGHT: plot_height_r <= cfg_data[ORG_W-1:0];
        REG_SCALE_X:     scale_x_r     <= cfg_data[COORD_W-1:0];
        REG_SCALE_Y:     scale_y_r     <= cfg_data[COORD_W-1:0];
        REG_EXTENT_X:    extent_x_r    <= cfg_data[COORD_W-1:0];
        REG_EXTENT_Y:    extent_y_r    <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  lbcp_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (take),
    .coef_a     (in_coef_a),
    .coef_b     (in_coef_b),
    .rhs        (in_rhs),
    .extent_x   (extent_x_r),
    .extent_y   (extent_y_r),
    .lane_valid (prep_v),
    .lane       (prep_lane)
  );

  lbcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_v),
    .in_lane   (prep_lane),
    .out_valid (div_v),
    .out_lane  (div_lane)
  );

  lbcp_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_v),
    .lane      (div_lane),
    .extent_x  (extent_x_r),
    .extent_y  (extent_y_r),
    .out_valid (sel_v),
    .visible   (sel_vis),
    .p0        (sel_p0),
    .p1        (sel_p1)
  );

  lbcp_pixel #(.FRAC_BITS(FRAC_BITS), .PIXEL_BITS(PIXEL_BITS)) u_pixel (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sel_v),
    .in_visible  (sel_vis),
    .p0          (sel_p0),
    .p1          (sel_p1),
    .scale_x     (scale_x_r),
    .scale_y     (scale_y_r),
    .origin_x    (origin_x_r),
    .origin_y    (origin_y_r),
    .plot_height (plot_height_r),
    .out_valid   (out_strobe),
    .out_visible (out_visible),
    .start_x     (out_start_x),
    .start_y     (out_start_y),
    .end_x       (out_end_x),
    .end_y       (out_end_y)
  );

endmodule
